FILE: rtl/mtf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_pkg: shared types for the move-to-front codec
// Command and status bundles between the sequencer and the list datapath,
// plus the fixed symbol width.
// ----------------------------------------------------------------------------
package mtf_pkg;

	// width of a byte symbol and of a rank
	localparam int unsigned SYM_W = 8;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic load;   // capture the accepted item
		logic clear;  // set the recency list back to identity
		logic rd;     // issue a list read at the scan pointer
		logic step;   // consume the returned entry: shift it back, test for hit
		logic front;  // write the found symbol to the head of the list
		logic emit;   // move the result into the output register
	} mtf_cmd_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic in_range;  // incoming symbol lies inside the alphabet
		logic ret;       // a read result is present this cycle
		logic hit;       // the returned entry is the one searched for
		logic ret_zero;  // the returned entry sits at the head of the list
		logic out_free;  // output register can take a result this cycle
	} mtf_sts_t;

endpackage
`default_nettype wire

FILE: rtl/mtf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_dp: recency list datapath
// Holds the list memory with per-entry valid bits (an entry that is not
// valid reads as its own index), the scan pointer, the shift carry, the
// configuration register and the output register.
// ----------------------------------------------------------------------------
module mtf_dp #(
	parameter int unsigned SYMBOLS = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_wdata,
	input  wire logic [mtf_pkg::SYM_W-1:0]     symbol_in,
	input  wire logic                          out_stall,
	output logic                               out_valid,
	output logic      [mtf_pkg::SYM_W-1:0]     symbol_out,
	input  wire mtf_pkg::mtf_cmd_t             cmd,
	output mtf_pkg::mtf_sts_t                  sts
);

	localparam int unsigned IDX_W = (SYMBOLS > 2) ? $clog2(SYMBOLS) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(SYMBOLS - 1);

	logic                        mode_q;
	logic [mtf_pkg::SYM_W-1:0]   sym_q;
	logic [IDX_W-1:0]            rd_k_q;
	logic [mtf_pkg::SYM_W-1:0]   list_mem_q [SYMBOLS];
	logic [SYMBOLS-1:0]          vld_q;
	logic [mtf_pkg::SYM_W-1:0]   rd_data_s1;
	logic                        rd_vld_s1;
	logic [IDX_W-1:0]            rd_addr_s1;
	logic                        ret_s1;
	logic [mtf_pkg::SYM_W-1:0]   carry_q;
	logic [mtf_pkg::SYM_W-1:0]   front_q;
	logic [mtf_pkg::SYM_W-1:0]   result_q;
	logic                        out_valid_q;
	logic [mtf_pkg::SYM_W-1:0]   symbol_out_q;

	logic [mtf_pkg::SYM_W-1:0]   entry;
	logic                        hit;
	logic                        ret_zero;
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_addr;
	logic [mtf_pkg::SYM_W-1:0]   wr_data;

	// entry that came back from the list; unwritten entries hold their index
	assign entry    = rd_vld_s1 ? rd_data_s1 : mtf_pkg::SYM_W'(rd_addr_s1);
	assign ret_zero = (rd_addr_s1 == '0);
	assign hit      = mode_q ? (rd_addr_s1 == sym_q[IDX_W-1:0]) : (entry == sym_q);

	// single write port: shift an entry back one place, or fill the head
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_addr_s1;
		wr_data = carry_q;
		if (cmd.front) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = front_q;
		end else if (cmd.step && !ret_zero) begin
			wr_en = 1'b1;
		end
	end

	assign sts.in_range = ({1'b0, symbol_in} < 9'(SYMBOLS));
	assign sts.ret      = ret_s1;
	assign sts.hit      = hit;
	assign sts.ret_zero = ret_zero;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign symbol_out = symbol_out_q;

	// control state: mode, valid bits, read return flag, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			vld_q       <= '0;
			ret_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (cmd.clear) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			ret_s1 <= cmd.rd;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// list memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			list_mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd) begin
			rd_data_s1 <= list_mem_q[rd_k_q];
			rd_vld_s1  <= vld_q[rd_k_q];
			rd_addr_s1 <= rd_k_q;
		end
	end

	// payload: captured item, scan pointer, carry, result, output data
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sym_q    <= symbol_in;
			rd_k_q   <= '0;
			result_q <= symbol_in;
		end else if (cmd.rd && (rd_k_q != LAST)) begin
			rd_k_q <= rd_k_q + 1'b1;
		end
		if (cmd.step) begin
			carry_q <= entry;
			if (hit) begin
				front_q  <= entry;
				result_q <= mode_q ? entry : mtf_pkg::SYM_W'(rd_addr_s1);
			end
		end
		if (cmd.emit) begin
			symbol_out_q <= result_q;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mtf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_ctrl: item sequencer
// Accepts one item, walks the recency list from the head until the target
// entry comes back, fills the head unless the rank is zero, and hands the
// result to the output register; out-of-alphabet items skip the walk.
// ----------------------------------------------------------------------------
module mtf_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               block_start,
	output logic                    in_stall,
	output mtf_pkg::mtf_cmd_t       cmd,
	input  wire mtf_pkg::mtf_sts_t  sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FRONT,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	// decode state into datapath commands and pick the next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					cmd.clear = block_start;
					state_d   = sts.in_range ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
				if (sts.ret) begin
					cmd.step = 1'b1;
					if (sts.hit) begin
						state_d = sts.ret_zero ? ST_DONE : ST_FRONT;
					end
				end
			end
			ST_FRONT: begin
				cmd.front = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/move_to_front_codec_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// move_to_front_codec_core: byte move-to-front encoder / decoder
// Input channel (in_valid / in_stall) carries symbol_in and block_start;
// output channel (out_valid / out_stall) carries symbol_out, one result
// per item. cfg_we / cfg_wdata write decode_mode (0 encode, 1 decode); the
// user must write it only while the block is idle; the block does not check.
// An item with block_start set first returns the list to identity by
// clearing the valid bits of the list memory.
// The time from acceptance to out_valid grows with p, the list position of
// the symbol (the rank); rank zero skips the head write, and a symbol
// outside the alphabet skips the walk. The list memory has one read and
// one write port and is walked one entry per cycle from the head.
// A new item can be taken in the cycle after the previous result is
// loaded, so an item is taken only once the previous one is through.
// in_stall is high while an item is in work. A result waits in the output
// register while out_stall is high; the next item is accepted meanwhile
// but finishes only once that register is free.
// Reset clears the list to identity and decode_mode to 0.
// ----------------------------------------------------------------------------
module move_to_front_codec_core #(
	parameter int unsigned SYMBOLS = 256
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [mtf_pkg::SYM_W-1:0]  symbol_in,
	input  wire logic                       block_start,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [mtf_pkg::SYM_W-1:0]  symbol_out
);

	mtf_pkg::mtf_cmd_t cmd;
	mtf_pkg::mtf_sts_t sts;

	// sequencer
	mtf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.block_start (block_start),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

	// list datapath
	mtf_dp #(
		.SYMBOLS (SYMBOLS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.symbol_in  (symbol_in),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.symbol_out (symbol_out),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule
`default_nettype wire

FILE: rtl/mtf_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_chk: port-level checks for the move-to-front codec
// Watches the channels of the top level over time; attached by bind.
// ----------------------------------------------------------------------------
module mtf_chk (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_stall,
	input wire logic                       out_valid,
	input wire logic                       out_stall,
	input wire logic [mtf_pkg::SYM_W-1:0]  symbol_out
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(symbol_out))
		else $error("symbol_out changed while stalled");

	// an accepted item keeps the input closed for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after an accepted item");

	// a new result never appears the cycle after an item is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result raised too early after acceptance");

	// a result is loaded only as the sequencer returns to idle
	a_rose_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result raised while an item is in work");

endmodule

bind move_to_front_codec_core mtf_chk u_mtf_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.symbol_out (symbol_out)
);
`default_nettype wire

FILE: verif/move_to_front_codec_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_codec_core_test: self-checking bench for the move-to-front codec
// Walks a short table of directed items in both modes, then random segments
// that alternate encode and decode under three idling patterns. A shadow
// recency list predicts each symbol_out the table does not type in, and
// results are compared in order against the queue of pending symbols.
// ----------------------------------------------------------------------------
module move_to_front_codec_core_test;

	localparam int unsigned ALPHABET = 256;
	localparam bit MODE_ENCODE = 1'b0;
	localparam bit MODE_DECODE = 1'b1;
	localparam int SEG_ITEMS = 205;
	localparam int SEGMENTS = 6;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 300;
	localparam int MAX_REPORTS = 10;
	localparam int WORK_SET = 8;

	typedef logic [mtf_pkg::SYM_W-1:0] sym_t;

	// one directed item: mode, payload, and an optional typed-in result
	typedef struct packed {
		logic dec;
		sym_t sym;
		logic bs;
		logic typed;
		sym_t val;
	} stim_row_t;

	localparam int N_DIRECTED = 19;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// encode from the identity list
		'{MODE_ENCODE, 8'h00, 1'b0, 1'b1, 8'h00},
		'{MODE_ENCODE, 8'hFF, 1'b0, 1'b1, 8'hFF},
		'{MODE_ENCODE, 8'hFF, 1'b0, 1'b1, 8'h00},
		'{MODE_ENCODE, 8'h00, 1'b0, 1'b1, 8'h01},
		'{MODE_ENCODE, 8'hAA, 1'b1, 1'b1, 8'hAA},
		'{MODE_ENCODE, 8'h55, 1'b0, 1'b0, 8'h00},
		'{MODE_ENCODE, 8'hAA, 1'b0, 1'b0, 8'h00},
		'{MODE_ENCODE, 8'h80, 1'b1, 1'b1, 8'h80},
		'{MODE_ENCODE, 8'h7F, 1'b0, 1'b0, 8'h00},
		// decode: rank zero, last rank, block restarts
		'{MODE_DECODE, 8'h00, 1'b1, 1'b1, 8'h00},
		'{MODE_DECODE, 8'hFF, 1'b0, 1'b1, 8'hFF},
		'{MODE_DECODE, 8'h00, 1'b0, 1'b1, 8'hFF},
		'{MODE_DECODE, 8'h01, 1'b0, 1'b0, 8'h00},
		'{MODE_DECODE, 8'hAA, 1'b1, 1'b1, 8'hAA},
		'{MODE_DECODE, 8'h55, 1'b0, 1'b0, 8'h00},
		'{MODE_DECODE, 8'hFF, 1'b1, 1'b1, 8'hFF},
		'{MODE_DECODE, 8'hFF, 1'b0, 1'b0, 8'h00},
		// back to encode: byte already at the front
		'{MODE_ENCODE, 8'h07, 1'b1, 1'b1, 8'h07},
		'{MODE_ENCODE, 8'h07, 1'b0, 1'b1, 8'h00}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sym_t symbol_in = '0;
	logic block_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	sym_t symbol_out;

	int tx_idle_pct = 7;
	int rx_idle_pct = 86;
	logic hold_go = 1'b0;
	logic hold_done;
	int hold_left;

	sym_t list_model [ALPHABET];
	logic mode_model;
	sym_t work_set [WORK_SET];
	sym_t out_symbol_due [$];
	int mismatch_count = 0;

	always #5 clk = ~clk;

	move_to_front_codec_core #(
		.SYMBOLS(ALPHABET)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.symbol_in(symbol_in),
		.block_start(block_start),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.symbol_out(symbol_out)
	);

	// advance the shadow list by one item and return the symbol it emits
	function automatic sym_t mtf_advance(input sym_t sym, input logic bs);
		int pos;
		int k;
		sym_t res;
		sym_t moved;
		if (bs) begin
			for (k = 0; k < ALPHABET; k++)
				list_model[k] = sym_t'(k);
		end
		res = sym;
		pos = -1;
		// outside the alphabet the symbol passes through and the list holds
		if (int'(sym) < ALPHABET) begin
			if (mode_model == MODE_DECODE) begin
				pos = int'(sym);
			end else begin
				for (k = 0; k < ALPHABET; k++)
					if (pos < 0 && list_model[k] == sym)
						pos = k;
			end
		end
		if (pos >= 0) begin
			moved = list_model[pos];
			res = (mode_model == MODE_DECODE) ? moved : sym_t'(pos);
			for (k = pos; k > 0; k--)
				list_model[k] = list_model[k - 1];
			list_model[0] = moved;
		end
		return res;
	endfunction

	task automatic report(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// offer one item, called at a falling edge; returns at the falling edge after acceptance
	task automatic offer_item(input sym_t sym, input logic bs, input logic typed,
			input sym_t val);
		sym_t want;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		symbol_in <= sym;
		block_start <= bs;
		do @(posedge clk); while (in_stall);
		want = mtf_advance(sym, bs);
		out_symbol_due.push_back(typed ? val : want);
		@(negedge clk);
	endtask

	// drain the block, then write decode_mode while it is idle
	task automatic set_mode(input logic m);
		in_valid <= 1'b0;
		while (out_symbol_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_model = m;
	endtask

	task automatic refill_work_set();
		foreach (work_set[i])
			work_set[i] = sym_t'($urandom_range(255));
	endtask

	// mostly recent symbols or low ranks, so ranks stay short, with some far reaches
	task automatic offer_random();
		logic bs;
		sym_t sym;
		int pick;
		bs = ($urandom_range(99) < 3);
		if (bs)
			refill_work_set();
		pick = $urandom_range(99);
		if (pick < 75)
			sym = (mode_model == MODE_DECODE) ? sym_t'($urandom_range(WORK_SET - 1))
				: work_set[$urandom_range(WORK_SET - 1)];
		else if (pick < 93)
			sym = sym_t'($urandom_range(255));
		else
			sym = pick[0] ? 8'hFF : 8'h00;
		offer_item(sym, bs, 1'b0, '0);
	endtask

	// stall the output at random, or throughout a hold-off
	always @(negedge clk)
		out_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);

	// count down the one long hold-off of the receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// compare each accepted result with the oldest pending symbol
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (out_symbol_due.size() == 0) begin
				report($sformatf("unexpected result symbol_out=%0d", symbol_out));
			end else begin
				if (symbol_out !== out_symbol_due[0])
					report($sformatf("symbol_out expected %0d got %0d",
						out_symbol_due[0], symbol_out));
				void'(out_symbol_due.pop_front());
			end
		end
	end

	initial begin
		mode_model = MODE_ENCODE;
		for (int k = 0; k < ALPHABET; k++)
			list_model[k] = sym_t'(k);
		refill_work_set();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].dec != mode_model)
				set_mode(DIRECTED[i].dec);
			offer_item(DIRECTED[i].sym, DIRECTED[i].bs, DIRECTED[i].typed, DIRECTED[i].val);
		end

		// random segments: two modes under each idling pattern
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			set_mode(seg[0] ? MODE_DECODE : MODE_ENCODE);
			case (seg / 2)
				0: begin
					tx_idle_pct = 7;
					rx_idle_pct <= 86;
				end
				1: begin
					tx_idle_pct = 86;
					rx_idle_pct <= 7;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct <= 0;
				end
			endcase
			// hold the receiver off once while items keep coming
			if (seg == 4)
				hold_go <= 1'b1;
			for (int n = 0; n < SEG_ITEMS; n++)
				offer_random();
		end

		in_valid <= 1'b0;
		while (out_symbol_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("move_to_front_codec_core_test: done, clean");
		else
			$display("move_to_front_codec_core_test: done, errors");
		$finish;
	end

	// end a hung run
	initial begin
		#20ms;
		$display("move_to_front_codec_core_test: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
rtl/mtf_pkg.sv
rtl/mtf_dp.sv
rtl/mtf_ctrl.sv
rtl/move_to_front_codec_core.sv
rtl/mtf_chk.sv
verif/move_to_front_codec_core_test.sv
